[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL; all are sampled on clk and off in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies b in the same cycle
`define ASSERT_IMPLIES(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// a implies b in the next cycle
`define ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

[hw/rtl/eztp_pkg.sv]
package eztp_pkg;

    localparam int ANG_W          = 34;  // Q2.30 with headroom for angles up to 4 rad
    localparam int TRIG_W         = 32;  // Q2.30 sine and cosine
    localparam int PROD_W         = 2 * TRIG_W;
    localparam int SUM_W          = PROD_W + 2;
    localparam int FIELD_W        = 16;
    localparam int ATAN_ENTRIES   = 24;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic signed [ANG_W-1:0] Q30_PI      = 34'sd3373259426;
    localparam logic signed [ANG_W-1:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [ANG_W-1:0] Q30_GAIN    = 34'sd652032874;
    localparam logic signed [19:0]      Q14_POS     = 20'sd16384;
    localparam logic signed [19:0]      Q14_NEG     = -20'sd16384;

    typedef struct packed {
        logic signed [ANG_W-1:0] x;
        logic signed [ANG_W-1:0] y;
        logic signed [ANG_W-1:0] z;
        logic                    flip;
    } eztp_cell_t;

    typedef struct packed {
        logic [FIELD_W-1:0] x;
        logic [FIELD_W-1:0] y;
        logic [FIELD_W-1:0] z;
    } eztp_pos_t;

    function automatic logic signed [ANG_W-1:0] atan_q30(input int i);
        logic signed [ANG_W-1:0] a;
        case (i)
            0:  a = 34'sh03243F6A8;
            1:  a = 34'sh01DAC6705;
            2:  a = 34'sh00FADBAFC;
            3:  a = 34'sh007F56EA6;
            4:  a = 34'sh003FEAB76;
            5:  a = 34'sh001FFD55B;
            6:  a = 34'sh000FFFAAA;
            7:  a = 34'sh0007FFF55;
            8:  a = 34'sh0003FFFEA;
            9:  a = 34'sh0001FFFFD;
            10: a = 34'sh0000FFFFF;
            11: a = 34'sh00007FFFF;
            12: a = 34'sh00003FFFF;
            13: a = 34'sh00001FFFF;
            14: a = 34'sh00000FFFF;
            15: a = 34'sh000007FFF;
            16: a = 34'sh000003FFF;
            17: a = 34'sh000001FFF;
            18: a = 34'sh000000FFF;
            19: a = 34'sh0000007FF;
            20: a = 34'sh0000003FF;
            21: a = 34'sh0000001FF;
            22: a = 34'sh0000000FF;
            default: a = 34'sh00000007F;
        endcase
        return a;
    endfunction

    // Q60 sum to Q1.14: round half up, then clamp to plus or minus one
    function automatic logic [FIELD_W-1:0] to_q14(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] t;
        logic signed [19:0]      r;
        t = v + (66'sd1 <<< 45);
        r = t[SUM_W-1:46];
        if (r > Q14_POS)
            r = Q14_POS;
        if (r < Q14_NEG)
            r = Q14_NEG;
        return r[FIELD_W-1:0];
    endfunction

endpackage

[hw/rtl/eztp_cordic_cell.sv]
module eztp_cordic_cell import eztp_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic       clk,
    input  logic       en,
    input  eztp_cell_t din,
    output eztp_cell_t dout
);

    localparam logic signed [ANG_W-1:0] ATAN = atan_q30(STEP);

    logic signed [ANG_W-1:0] x, y, z, dx, dy;
    eztp_cell_t dout_next, dout_reg;

    always_comb
    begin
        x = din.x;
        y = din.y;
        z = din.z;
        dx = y >>> STEP;
        dy = x >>> STEP;
        dout_next.flip = din.flip;
        if (!z[ANG_W-1])
        begin
            dout_next.x = x - dx;
            dout_next.y = y + dy;
            dout_next.z = z - ATAN;
        end
        else
        begin
            dout_next.x = x + dx;
            dout_next.y = y - dy;
            dout_next.z = z + ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

[hw/rtl/eztp_matrix.sv]
module eztp_matrix import eztp_pkg::*; (
    input  logic                      clk,
    input  logic                      en,
    input  eztp_cell_t                roll,
    input  eztp_cell_t                pitch,
    input  eztp_cell_t                yaw,
    output logic [8:0][FIELD_W-1:0]   m
);

    // stage 1: undo folding, narrow to Q2.30
    logic signed [TRIG_W-1:0] sr_reg, cr_reg, sp_reg, cp_reg, sy_reg, cy_reg;
    logic signed [ANG_W-1:0]  sr_next, cr_next, sp_next, cp_next, sy_next, cy_next;

    always_comb
    begin
        sr_next = roll.flip  ? -roll.y  : roll.y;
        cr_next = roll.flip  ? -roll.x  : roll.x;
        sp_next = pitch.flip ? -pitch.y : pitch.y;
        cp_next = pitch.flip ? -pitch.x : pitch.x;
        sy_next = yaw.flip   ? -yaw.y   : yaw.y;
        cy_next = yaw.flip   ? -yaw.x   : yaw.x;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sr_reg <= sr_next[TRIG_W-1:0];
            cr_reg <= cr_next[TRIG_W-1:0];
            sp_reg <= sp_next[TRIG_W-1:0];
            cp_reg <= cp_next[TRIG_W-1:0];
            sy_reg <= sy_next[TRIG_W-1:0];
            cy_reg <= cy_next[TRIG_W-1:0];
        end
    end

    // stage 2: pairwise products
    logic signed [PROD_W-1:0] cysp2_reg, sysp2_reg, cycp2_reg, sycp2_reg, cpsr2_reg, cpcr2_reg;
    logic signed [PROD_W-1:0] sycr2_reg, sysr2_reg, cycr2_reg, cysr2_reg;
    logic signed [TRIG_W-1:0] sr2_reg, cr2_reg, sp2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cysp2_reg <= cy_reg * sp_reg;
            sysp2_reg <= sy_reg * sp_reg;
            cycp2_reg <= cy_reg * cp_reg;
            sycp2_reg <= sy_reg * cp_reg;
            cpsr2_reg <= cp_reg * sr_reg;
            cpcr2_reg <= cp_reg * cr_reg;
            sycr2_reg <= sy_reg * cr_reg;
            sysr2_reg <= sy_reg * sr_reg;
            cycr2_reg <= cy_reg * cr_reg;
            cysr2_reg <= cy_reg * sr_reg;
            sr2_reg   <= sr_reg;
            cr2_reg   <= cr_reg;
            sp2_reg   <= sp_reg;
        end
    end

    // stage 3: round the left pairs back to Q2.30
    logic signed [PROD_W-1:0] cysp_rnd, sysp_rnd;
    logic signed [TRIG_W-1:0] cysp3_reg, sysp3_reg, sr3_reg, cr3_reg, sp3_reg;
    logic signed [PROD_W-1:0] cycp3_reg, sycp3_reg, cpsr3_reg, cpcr3_reg;
    logic signed [PROD_W-1:0] sycr3_reg, sysr3_reg, cycr3_reg, cysr3_reg;

    assign cysp_rnd = (cysp2_reg + (64'sd1 <<< 29)) >>> 30;
    assign sysp_rnd = (sysp2_reg + (64'sd1 <<< 29)) >>> 30;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cysp3_reg <= cysp_rnd[TRIG_W-1:0];
            sysp3_reg <= sysp_rnd[TRIG_W-1:0];
            sr3_reg   <= sr2_reg;
            cr3_reg   <= cr2_reg;
            sp3_reg   <= sp2_reg;
            cycp3_reg <= cycp2_reg;
            sycp3_reg <= sycp2_reg;
            cpsr3_reg <= cpsr2_reg;
            cpcr3_reg <= cpcr2_reg;
            sycr3_reg <= sycr2_reg;
            sysr3_reg <= sysr2_reg;
            cycr3_reg <= cycr2_reg;
            cysr3_reg <= cysr2_reg;
        end
    end

    // stage 4: triple products
    logic signed [PROD_W-1:0] cyspsr4_reg, cyspcr4_reg, syspsr4_reg, syspcr4_reg;
    logic signed [PROD_W-1:0] cycp4_reg, sycp4_reg, cpsr4_reg, cpcr4_reg;
    logic signed [PROD_W-1:0] sycr4_reg, sysr4_reg, cycr4_reg, cysr4_reg;
    logic signed [TRIG_W-1:0] sp4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cyspsr4_reg <= cysp3_reg * sr3_reg;
            cyspcr4_reg <= cysp3_reg * cr3_reg;
            syspsr4_reg <= sysp3_reg * sr3_reg;
            syspcr4_reg <= sysp3_reg * cr3_reg;
            cycp4_reg   <= cycp3_reg;
            sycp4_reg   <= sycp3_reg;
            cpsr4_reg   <= cpsr3_reg;
            cpcr4_reg   <= cpcr3_reg;
            sycr4_reg   <= sycr3_reg;
            sysr4_reg   <= sysr3_reg;
            cycr4_reg   <= cycr3_reg;
            cysr4_reg   <= cysr3_reg;
            sp4_reg     <= sp3_reg;
        end
    end

    // stage 5: combine, round and clamp
    logic signed [SUM_W-1:0] e [9];
    logic [8:0][FIELD_W-1:0] m_reg;

    always_comb
    begin
        e[0] = SUM_W'(cycp4_reg);
        e[1] = SUM_W'(cyspsr4_reg) - SUM_W'(sycr4_reg);
        e[2] = SUM_W'(cyspcr4_reg) + SUM_W'(sysr4_reg);
        e[3] = SUM_W'(sycp4_reg);
        e[4] = SUM_W'(syspsr4_reg) + SUM_W'(cycr4_reg);
        e[5] = SUM_W'(syspcr4_reg) - SUM_W'(cysr4_reg);
        e[6] = -(SUM_W'(sp4_reg) <<< 30);
        e[7] = SUM_W'(cpsr4_reg);
        e[8] = SUM_W'(cpcr4_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 9; k++)
                m_reg[k] <= to_q14(e[k]);
        end
    end

    assign m = m_reg;

endmodule

[hw/rtl/euler_zyx_to_pose_matrix.sv]
// Z-Y-X Euler pose to the upper three rows of a homogeneous transform.
// Input channel: in_valid/in_ready carry one pose request (pos_x/y/z in Q0.15,
// roll/pitch/yaw angles in Q2.13 radians). Output channel: out_valid/out_ready
// carry m00..m22 (Q1.14, clamped to plus or minus one) and out_x/y/z, the
// translation copied through.
// Throughput: one request per cycle while the skid register is empty. From
// acceptance to out_valid, the request is registered into one angle fold
// stage at the accepting edge, then passes one CORDIC cell per step (steps
// capped at 24; the three angles run in parallel cell rows), five matrix
// stages (negate, products, rounding, triple products, sum and clamp) and
// the output register.
// When the receiver stalls, a one-entry skid register catches the result
// leaving the pipeline; the whole pipeline then holds and in_ready drops
// until the skid entry drains.
// Reset clears only the valid bits; no request is in flight afterwards.
`include "assert_macros.svh"

module euler_zyx_to_pose_matrix import eztp_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [FIELD_W-1:0]  pos_x,
    input  logic signed [FIELD_W-1:0]  pos_y,
    input  logic signed [FIELD_W-1:0]  pos_z,
    input  logic signed [FIELD_W-1:0]  roll_angle,
    input  logic signed [FIELD_W-1:0]  pitch_angle,
    input  logic signed [FIELD_W-1:0]  yaw_angle,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [FIELD_W-1:0]  m00,
    output logic signed [FIELD_W-1:0]  m01,
    output logic signed [FIELD_W-1:0]  m02,
    output logic signed [FIELD_W-1:0]  m10,
    output logic signed [FIELD_W-1:0]  m11,
    output logic signed [FIELD_W-1:0]  m12,
    output logic signed [FIELD_W-1:0]  m20,
    output logic signed [FIELD_W-1:0]  m21,
    output logic signed [FIELD_W-1:0]  m22,
    output logic signed [FIELD_W-1:0]  out_x,
    output logic signed [FIELD_W-1:0]  out_y,
    output logic signed [FIELD_W-1:0]  out_z
);

    localparam int NSTEP = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
    localparam int NSTG  = 1 + NSTEP + 5;

    logic en;
    logic ov_reg, sv_reg, p_v;
    logic [NSTG-1:0] v_reg;

    assign en       = !sv_reg;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NSTG-2:0], in_valid};
    end

    // translation rides alongside the pipeline
    eztp_pos_t pos_reg [NSTG];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_reg[0] <= '{x: pos_x, y: pos_y, z: pos_z};
            for (int k = 1; k < NSTG; k++)
                pos_reg[k] <= pos_reg[k-1];
        end
    end

    // fold stage: bring each angle into plus or minus pi/2
    function automatic eztp_cell_t fold(input logic signed [FIELD_W-1:0] a);
        eztp_cell_t c;
        logic signed [ANG_W-1:0] z;
        z = {{(ANG_W-FIELD_W-17){a[FIELD_W-1]}}, a, 17'b0};
        c.x = Q30_GAIN;
        c.y = '0;
        c.flip = 1'b0;
        c.z = z;
        if (z > Q30_HALF_PI)
        begin
            c.z = z - Q30_PI;
            c.flip = 1'b1;
        end
        else if (z < -Q30_HALF_PI)
        begin
            c.z = z + Q30_PI;
            c.flip = 1'b1;
        end
        return c;
    endfunction

    eztp_cell_t roll_c [NSTEP+1];
    eztp_cell_t pitch_c [NSTEP+1];
    eztp_cell_t yaw_c [NSTEP+1];
    eztp_cell_t roll_f_reg, pitch_f_reg, yaw_f_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_f_reg  <= fold(roll_angle);
            pitch_f_reg <= fold(pitch_angle);
            yaw_f_reg   <= fold(yaw_angle);
        end
    end

    assign roll_c[0]  = roll_f_reg;
    assign pitch_c[0] = pitch_f_reg;
    assign yaw_c[0]   = yaw_f_reg;

    for (genvar i = 0; i < NSTEP; i++)
    begin : g_cells
        eztp_cordic_cell #(.STEP(i)) u_roll (
            .clk(clk), .en(en), .din(roll_c[i]), .dout(roll_c[i+1]));
        eztp_cordic_cell #(.STEP(i)) u_pitch (
            .clk(clk), .en(en), .din(pitch_c[i]), .dout(pitch_c[i+1]));
        eztp_cordic_cell #(.STEP(i)) u_yaw (
            .clk(clk), .en(en), .din(yaw_c[i]), .dout(yaw_c[i+1]));
    end

    logic [8:0][FIELD_W-1:0] mat;

    eztp_matrix u_matrix (
        .clk(clk),
        .en(en),
        .roll(roll_c[NSTEP]),
        .pitch(pitch_c[NSTEP]),
        .yaw(yaw_c[NSTEP]),
        .m(mat)
    );

    typedef struct packed {
        logic [8:0][FIELD_W-1:0] m;
        eztp_pos_t               pos;
    } eztp_res_t;

    eztp_res_t p_res, out_reg, skid_reg;

    assign p_res = '{m: mat, pos: pos_reg[NSTG-1]};
    assign p_v   = v_reg[NSTG-1] && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            sv_reg <= 1'b0;
        end
        else if (!ov_reg || out_ready)
        begin
            // drain skid first, else take the pipeline head
            ov_reg <= sv_reg || p_v;
            sv_reg <= 1'b0;
        end
        else if (p_v)
            sv_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!ov_reg || out_ready)
            out_reg <= sv_reg ? skid_reg : p_res;
        else if (p_v)
            skid_reg <= p_res;
    end

    assign out_valid = ov_reg;
    assign m00   = out_reg.m[0];
    assign m01   = out_reg.m[1];
    assign m02   = out_reg.m[2];
    assign m10   = out_reg.m[3];
    assign m11   = out_reg.m[4];
    assign m12   = out_reg.m[5];
    assign m20   = out_reg.m[6];
    assign m21   = out_reg.m[7];
    assign m22   = out_reg.m[8];
    assign out_x = out_reg.pos.x;
    assign out_y = out_reg.pos.y;
    assign out_z = out_reg.pos.z;

    `ASSERT_IMPLIES(a_skid_needs_out, sv_reg, ov_reg)
    `ASSERT_NEXT(a_skid_holds, sv_reg && !out_ready, sv_reg && ov_reg)
    `ASSERT_IMPLIES(a_m00_range, out_valid, (m00 <= 16'sd16384) && (m00 >= -16'sd16384))
    `ASSERT_NEXT(a_no_loss, ov_reg && !out_ready && p_v, sv_reg)

endmodule
